[design/aezv_pkg.sv]
// ----------------------------------------------------------------------------
// aezv_pkg
// shared constants, register indexes and word types of the voice activity
// detector
// ----------------------------------------------------------------------------
package aezv_pkg;

  localparam int HistDepth  = 128;
  localparam int HistAw     = $clog2(HistDepth);
  localparam int CntW       = $clog2(HistDepth + 1);
  localparam int MaxFrame   = 1024;
  localparam int FrW        = $clog2(MaxFrame + 1);
  localparam int CrossW     = $clog2(MaxFrame);
  localparam int SampleW    = 16;
  localparam int AbsW       = SampleW + $clog2(MaxFrame);
  localparam int EnW        = 24;
  localparam int SumW       = EnW + HistAw;
  localparam int SqW        = 2 * EnW + HistAw;
  localparam int VarW       = 48;
  localparam int DivNW      = SqW;
  localparam int DivDW      = FrW;
  localparam int DivCntW    = $clog2(DivNW);
  localparam int SfW        = 8;
  localparam int K2W        = 2 * SfW;
  localparam int K2vW       = 64;
  localparam int KCntW      = $clog2(K2W);
  localparam int ZcrW       = 16;
  localparam int RunW       = 8;
  localparam int SilenceMax = 5;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_CAL_FRAMES = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SIGMA      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ZCR_LOW    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ZCR_HIGH   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_SPEECH = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [SampleW-1:0] sample;
    logic                      frame_last;
  } in_word_t;

  typedef struct packed {
    logic speech;
    logic calibrating;
  } out_word_t;

endpackage

[design/adaptive_energy_zcr_vad.sv]
// ----------------------------------------------------------------------------
// adaptive_energy_zcr_vad
// Voice activity detector on frame energy and zero crossing rate.
//
// Input words carry one audio sample (or a run-counter clear) and a frame
// last flag. A mid-frame sample or a clear leaves the input unstalled and
// gives no output word. The last sample of a frame gives one output word.
// Frame end work runs on one shared restoring divider, a serial
// multiply-accumulate for sigma^2 * variance and a walk over the history
// memory. Frame end paths:
//   calibration frame, not last:        energy division, then output
//   calibration end / history update:   add a mean and variance pass over
//                                       the n entries used (up to 128)
//   running frame, no update:           energy division, threshold, output
// The block stalls its input while frame end work runs.
// The output word sits in a register; when the receiver stalls it holds,
// and samples are still taken meanwhile, but the next frame end waits.
// After reset the history reads as zero, the configuration registers hold
// their defaults and the block starts calibrating.
// ----------------------------------------------------------------------------
module adaptive_energy_zcr_vad (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [aezv_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [aezv_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  aezv_pkg::in_word_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output aezv_pkg::out_word_t                out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDIV, ST_ZCR, ST_CAL, ST_K2V, ST_LHS, ST_CMP, ST_SUMRD,
    ST_SUMACC, ST_MDIV, ST_VARRD, ST_VARACC, ST_VDIV, ST_POST, ST_RUN, ST_OUT
  } state_e;

  state_e st_q;

  // configuration
  logic [7:0]                  cal_frames_q;
  logic [aezv_pkg::SfW-1:0]    sigma_q;
  logic [aezv_pkg::ZcrW-1:0]   zcr_low_q;
  logic [aezv_pkg::ZcrW-1:0]   zcr_high_q;
  logic [aezv_pkg::RunW-1:0]   min_speech_q;

  // frame accumulation
  logic [aezv_pkg::AbsW-1:0]   fr_sum_q;
  logic [aezv_pkg::FrW-1:0]    fr_cnt_q;
  logic [aezv_pkg::CrossW-1:0] fr_cross_q;
  logic                        prev_sign_q;
  logic [aezv_pkg::FrW-1:0]    fr_n_q;
  logic [aezv_pkg::CrossW-1:0] fr_x_q;

  // detector state
  logic                        running_q;
  logic [aezv_pkg::CntW-1:0]   calib_cnt_q;
  logic [aezv_pkg::HistAw-1:0] wp_q;
  logic [aezv_pkg::CntW-1:0]   used_q;
  logic [aezv_pkg::EnW-1:0]    mean_q;
  logic [aezv_pkg::VarW-1:0]   var_q;
  logic [aezv_pkg::RunW-1:0]   speech_run_q;
  logic [aezv_pkg::RunW-1:0]   silence_run_q;

  // work registers
  logic [aezv_pkg::EnW-1:0]    energy_q;
  logic                        zok_q;
  logic                        cal_q;
  logic                        ph_q;
  logic                        spike_q;
  logic [aezv_pkg::CntW-1:0]   nst_q;
  logic [aezv_pkg::CntW-1:0]   idx_q;
  logic [aezv_pkg::SumW-1:0]   sum_q;
  logic [aezv_pkg::SqW-1:0]    sq_q;
  logic [aezv_pkg::K2W-1:0]    k2_q;
  logic [aezv_pkg::KCntW-1:0]  kcnt_q;
  logic [aezv_pkg::K2vW-1:0]   k2v_q;
  logic [2*aezv_pkg::EnW+7:0]  lhs_q;
  logic                        neg_q;
  aezv_pkg::out_word_t         res_q;
  logic                        out_valid_q;
  aezv_pkg::out_word_t         out_data_q;

  // shared divider
  logic [aezv_pkg::DivNW-1:0]   div_num_q;
  logic [aezv_pkg::DivDW-1:0]   div_den_q;
  logic [aezv_pkg::DivDW-1:0]   div_rem_q;
  logic [aezv_pkg::DivCntW-1:0] div_cnt_q;
  logic [aezv_pkg::DivDW:0]     div_t;
  logic                         div_ge;
  logic [aezv_pkg::DivDW-1:0]   div_rem_d;
  logic [aezv_pkg::DivNW-1:0]   div_quo_d;
  logic                         div_last;

  // history memory
  logic [aezv_pkg::EnW-1:0]       hist_mem [aezv_pkg::HistDepth];
  logic [aezv_pkg::HistDepth-1:0] hist_vld_q;
  logic [aezv_pkg::EnW-1:0]       hist_rd_q;
  logic                           rd_vld_q;
  logic                           mem_we;
  logic [aezv_pkg::HistAw-1:0]    mem_waddr;
  logic [aezv_pkg::EnW-1:0]       rd_val;

  // combinational helpers
  logic                        in_acc;
  logic                        s_neg;
  logic [aezv_pkg::SampleW-1:0] s_mag;
  logic                        fr_take;
  logic [aezv_pkg::FrW-1:0]    fr_cnt_nx;
  logic [aezv_pkg::AbsW-1:0]   fr_sum_nx;
  logic [aezv_pkg::CrossW-1:0] fr_cross_nx;
  logic [aezv_pkg::FrW-1:0]    span;
  logic [aezv_pkg::ZcrW+aezv_pkg::FrW-1:0] zlo, zhi, zc;
  logic                        zok;
  logic [aezv_pkg::CntW-1:0]   cf;
  logic [aezv_pkg::CntW-1:0]   n_upd;
  logic [aezv_pkg::EnW-1:0]    dvar;
  logic [aezv_pkg::EnW-1:0]    dthr;
  logic                        lt, gt;
  logic                        hit;
  logic [aezv_pkg::RunW-1:0]   speech_nx, silence_nx;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // sample magnitude and frame accumulation
  assign s_neg       = in_data_i.sample[aezv_pkg::SampleW-1];
  assign s_mag       = s_neg ? (~in_data_i.sample + 16'd1) : in_data_i.sample;
  assign fr_take     = fr_cnt_q < aezv_pkg::FrW'(aezv_pkg::MaxFrame);
  assign fr_cnt_nx   = fr_take ? fr_cnt_q + 1'b1 : fr_cnt_q;
  assign fr_sum_nx   = fr_take ? fr_sum_q + aezv_pkg::AbsW'(s_mag) : fr_sum_q;
  assign fr_cross_nx = (fr_take && fr_cnt_q != '0 && (!s_neg) != prev_sign_q)
                       ? fr_cross_q + 1'b1 : fr_cross_q;

  // divider step
  assign div_t     = {div_rem_q, div_num_q[aezv_pkg::DivNW-1]};
  assign div_ge    = div_t >= {1'b0, div_den_q};
  assign div_rem_d = div_ge ? aezv_pkg::DivDW'(div_t - {1'b0, div_den_q})
                            : div_t[aezv_pkg::DivDW-1:0];
  assign div_quo_d = {div_num_q[aezv_pkg::DivNW-2:0], div_ge};
  assign div_last  = div_cnt_q == aezv_pkg::DivCntW'(aezv_pkg::DivNW - 1);

  // crossing rate window
  assign span = fr_n_q - 1'b1;
  assign zlo  = zcr_low_q * span;
  assign zhi  = zcr_high_q * span;
  assign zc   = (aezv_pkg::ZcrW + aezv_pkg::FrW)'({fr_x_q, 16'd0});
  assign zok  = (fr_n_q < aezv_pkg::FrW'(2)) ? (zcr_low_q == '0)
                                             : (zc >= zlo && zc <= zhi);

  // effective calibration length
  always_comb begin
    if (cal_frames_q == 8'd0) begin
      cf = aezv_pkg::CntW'(1);
    end else if (32'(cal_frames_q) > aezv_pkg::HistDepth) begin
      cf = aezv_pkg::CntW'(aezv_pkg::HistDepth);
    end else begin
      cf = aezv_pkg::CntW'(cal_frames_q);
    end
  end

  assign n_upd = (used_q >= aezv_pkg::CntW'(aezv_pkg::HistDepth))
                 ? aezv_pkg::CntW'(aezv_pkg::HistDepth) : used_q + 1'b1;

  assign rd_val = rd_vld_q ? hist_rd_q : '0;
  assign dvar   = (rd_val >= mean_q) ? rd_val - mean_q : mean_q - rd_val;
  assign dthr   = energy_q - mean_q;

  assign lt = neg_q || (aezv_pkg::K2vW'(lhs_q) < k2v_q);
  assign gt = !neg_q && (aezv_pkg::K2vW'(lhs_q) > k2v_q);

  // run counters
  assign hit = spike_q && zok_q;
  always_comb begin
    speech_nx  = speech_run_q;
    silence_nx = silence_run_q;
    if (hit) begin
      if (speech_run_q != '1) speech_nx = speech_run_q + 1'b1;
      silence_nx = '0;
    end else begin
      if (silence_run_q != '1) silence_nx = silence_run_q + 1'b1;
      if (silence_nx > aezv_pkg::RunW'(aezv_pkg::SilenceMax)) speech_nx = '0;
    end
  end

  // history write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    if (st_q == ST_CAL) begin
      mem_we    = calib_cnt_q < aezv_pkg::CntW'(aezv_pkg::HistDepth);
      mem_waddr = calib_cnt_q[aezv_pkg::HistAw-1:0];
    end else if (st_q == ST_CMP && !ph_q && lt) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= energy_q;
    end
    hist_rd_q <= hist_mem[idx_q[aezv_pkg::HistAw-1:0]];
    rd_vld_q  <= hist_vld_q[idx_q[aezv_pkg::HistAw-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_IDLE;
      cal_frames_q  <= 8'd100;
      sigma_q       <= 8'd48;
      zcr_low_q     <= 16'd3277;
      zcr_high_q    <= 16'd32768;
      min_speech_q  <= 8'd3;
      fr_sum_q      <= '0;
      fr_cnt_q      <= '0;
      fr_cross_q    <= '0;
      prev_sign_q   <= 1'b0;
      fr_n_q        <= '0;
      fr_x_q        <= '0;
      running_q     <= 1'b0;
      calib_cnt_q   <= '0;
      wp_q          <= '0;
      used_q        <= '0;
      mean_q        <= '0;
      var_q         <= '0;
      speech_run_q  <= '0;
      silence_run_q <= '0;
      hist_vld_q    <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      res_q         <= '0;
      energy_q      <= '0;
      zok_q         <= 1'b0;
      spike_q       <= 1'b0;
      neg_q         <= 1'b0;
      nst_q         <= '0;
      sum_q         <= '0;
      sq_q          <= '0;
      k2_q          <= '0;
      kcnt_q        <= '0;
      k2v_q         <= '0;
      lhs_q         <= '0;
      div_num_q     <= '0;
      div_den_q     <= '0;
      div_rem_q     <= '0;
      div_cnt_q     <= '0;
      cal_q         <= 1'b0;
      ph_q          <= 1'b0;
      idx_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          aezv_pkg::REG_CAL_FRAMES: cal_frames_q <= cfg_data_i[7:0];
          aezv_pkg::REG_SIGMA:      sigma_q      <= cfg_data_i[7:0];
          aezv_pkg::REG_ZCR_LOW:    zcr_low_q    <= cfg_data_i;
          aezv_pkg::REG_ZCR_HIGH:   zcr_high_q   <= cfg_data_i;
          aezv_pkg::REG_MIN_SPEECH: min_speech_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (mem_we) begin
        hist_vld_q[mem_waddr] <= 1'b1;
      end
      if (out_valid_q && !out_stall_i && st_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data_i.op == aezv_pkg::OP_CLEAR) begin
              speech_run_q  <= '0;
              silence_run_q <= '0;
            end else if (in_data_i.frame_last) begin
              fr_n_q      <= fr_cnt_nx;
              fr_x_q      <= fr_cross_nx;
              fr_sum_q    <= '0;
              fr_cnt_q    <= '0;
              fr_cross_q  <= '0;
              prev_sign_q <= 1'b0;
              div_num_q   <= aezv_pkg::DivNW'({fr_sum_nx, 8'd0});
              div_den_q   <= fr_cnt_nx;
              div_rem_q   <= '0;
              div_cnt_q   <= '0;
              st_q        <= ST_EDIV;
            end else begin
              fr_sum_q   <= fr_sum_nx;
              fr_cnt_q   <= fr_cnt_nx;
              fr_cross_q <= fr_cross_nx;
              if (fr_take) prev_sign_q <= !s_neg;
            end
          end
        end
        ST_EDIV: begin
          div_num_q <= div_quo_d;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            energy_q <= div_quo_d[aezv_pkg::EnW-1:0];
            st_q     <= ST_ZCR;
          end
        end
        ST_ZCR: begin
          zok_q <= zok;
          ph_q  <= 1'b0;
          if (running_q) begin
            k2_q   <= sigma_q * sigma_q;
            k2v_q  <= '0;
            kcnt_q <= '0;
            st_q   <= ST_K2V;
          end else begin
            st_q <= ST_CAL;
          end
        end
        ST_CAL: begin
          calib_cnt_q <= calib_cnt_q + 1'b1;
          res_q.speech      <= 1'b0;
          res_q.calibrating <= 1'b1;
          if (calib_cnt_q + 1'b1 >= cf) begin
            running_q <= 1'b1;
            wp_q      <= '0;
            used_q    <= cf;
            nst_q     <= cf;
            cal_q     <= 1'b1;
            idx_q     <= '0;
            sum_q     <= '0;
            st_q      <= ST_SUMRD;
          end else begin
            st_q <= ST_OUT;
          end
        end
        ST_K2V: begin
          k2v_q  <= k2v_q + (k2_q[kcnt_q] ? (aezv_pkg::K2vW'(var_q) << kcnt_q)
                                           : aezv_pkg::K2vW'(0));
          kcnt_q <= kcnt_q + 1'b1;
          if (kcnt_q == aezv_pkg::KCntW'(aezv_pkg::K2W - 1)) st_q <= ST_LHS;
        end
        ST_LHS: begin
          neg_q <= energy_q < mean_q;
          lhs_q <= {dthr, 4'd0} * {dthr, 4'd0};
          st_q  <= ST_CMP;
        end
        ST_CMP: begin
          if (!ph_q && lt) begin
            wp_q   <= wp_q + 1'b1;
            used_q <= n_upd;
            nst_q  <= n_upd;
            cal_q  <= 1'b0;
            idx_q  <= '0;
            sum_q  <= '0;
            st_q   <= ST_SUMRD;
          end else begin
            spike_q <= (var_q != '0) && gt;
            st_q    <= ST_RUN;
          end
        end
        ST_SUMRD: begin
          st_q <= ST_SUMACC;
        end
        ST_SUMACC: begin
          sum_q <= sum_q + aezv_pkg::SumW'(rd_val);
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 == nst_q) begin
            div_num_q <= aezv_pkg::DivNW'(sum_q + aezv_pkg::SumW'(rd_val));
            div_den_q <= aezv_pkg::DivDW'(nst_q);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            st_q      <= ST_MDIV;
          end else begin
            st_q <= ST_SUMRD;
          end
        end
        ST_MDIV: begin
          div_num_q <= div_quo_d;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            mean_q <= div_quo_d[aezv_pkg::EnW-1:0];
            idx_q  <= '0;
            sq_q   <= '0;
            if (nst_q <= aezv_pkg::CntW'(1)) begin
              var_q <= '0;
              st_q  <= ST_POST;
            end else begin
              st_q <= ST_VARRD;
            end
          end
        end
        ST_VARRD: begin
          st_q <= ST_VARACC;
        end
        ST_VARACC: begin
          sq_q  <= sq_q + aezv_pkg::SqW'(dvar * dvar);
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 == nst_q) begin
            div_num_q <= aezv_pkg::DivNW'(sq_q + aezv_pkg::SqW'(dvar * dvar));
            div_den_q <= aezv_pkg::DivDW'(nst_q - 1'b1);
            div_rem_q <= '0;
            div_cnt_q <= '0;
            st_q      <= ST_VDIV;
          end else begin
            st_q <= ST_VARRD;
          end
        end
        ST_VDIV: begin
          div_num_q <= div_quo_d;
          div_rem_q <= div_rem_d;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            var_q <= div_quo_d[aezv_pkg::VarW-1:0];
            st_q  <= ST_POST;
          end
        end
        ST_POST: begin
          if (cal_q) begin
            st_q <= ST_OUT;
          end else begin
            ph_q   <= 1'b1;
            k2_q   <= sigma_q * sigma_q;
            k2v_q  <= '0;
            kcnt_q <= '0;
            st_q   <= ST_K2V;
          end
        end
        ST_RUN: begin
          speech_run_q      <= speech_nx;
          silence_run_q     <= silence_nx;
          res_q.speech      <= speech_nx >= min_speech_q;
          res_q.calibrating <= 1'b0;
          st_q              <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            st_q        <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/aezv_checker.sv]
// ----------------------------------------------------------------------------
// aezv_checker
// port level checks of the voice activity detector
// ----------------------------------------------------------------------------
module aezv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input aezv_pkg::in_word_t            in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input aezv_pkg::out_word_t           out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped or changed under stall");

  // frame end starts busy work
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.op == aezv_pkg::OP_SAMPLE && in_data_i.frame_last
    |=> in_stall_o)
    else $error("frame end not processed");

  // clear and mid-frame words leave the input unstalled
  a_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.op == aezv_pkg::OP_CLEAR || !in_data_i.frame_last)
    |=> !in_stall_o)
    else $error("short word stalled input");

  // speech is never reported during calibration
  a_no_cal_speech: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.speech && out_data_o.calibrating))
    else $error("speech during calibration");

  // configuration changes only while no frame end work runs
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_stall_o)
    else $error("configuration written while busy");

endmodule

bind adaptive_energy_zcr_vad aezv_checker u_aezv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the energy and zero crossing voice activity
// detector. Frames of quiet and loud samples, clear words and an overlong
// frame are driven with random idle and stall bursts. A scoreboard predicts
// every output word from its own model of calibration, history ring,
// threshold and run counters, and checks each output word against it.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 900;

  class vad_scoreboard;
    bit [7:0] cal_frames, sigma, min_run;
    bit [15:0] zlow, zhigh;
    bit [23:0] hist[aezv_pkg::HistDepth];
    bit running, prev_sign;
    int unsigned cal_cnt, wr_ptr, used;
    bit [23:0] bg_mean;
    longint unsigned bg_var, abs_sum;
    int unsigned smp_cnt, crossings, speech_run, silence_run;
    aezv_pkg::out_word_t pending_q[$];
    int errors;

    function new();
      cal_frames = 100; sigma = 48; zlow = 3277; zhigh = 32768; min_run = 3;
      foreach (hist[i]) hist[i] = '0;
      running = 0; prev_sign = 0; cal_cnt = 0; wr_ptr = 0; used = 0;
      bg_mean = 0; bg_var = 0; abs_sum = 0; smp_cnt = 0; crossings = 0;
      speech_run = 0; silence_run = 0; errors = 0;
    endfunction

    function void set_reg(logic [aezv_pkg::CfgIdxW-1:0] idx,
                          logic [aezv_pkg::CfgDataW-1:0] val);
      case (idx)
        aezv_pkg::REG_CAL_FRAMES: cal_frames = val[7:0];
        aezv_pkg::REG_SIGMA:      sigma = val[7:0];
        aezv_pkg::REG_ZCR_LOW:    zlow = val;
        aezv_pkg::REG_ZCR_HIGH:   zhigh = val;
        aezv_pkg::REG_MIN_SPEECH: min_run = val[7:0];
        default: ;
      endcase
    endfunction

    function void update_stats(int unsigned n);
      longint unsigned acc, sq, e, d;
      acc = 0;
      sq = 0;
      if (n > aezv_pkg::HistDepth) n = aezv_pkg::HistDepth;
      if (n == 0) begin
        bg_mean = 0;
        bg_var = 0;
        return;
      end
      for (int i = 0; i < n; i++) acc += hist[i];
      bg_mean = 24'(acc / n);
      if (n <= 1) begin
        bg_var = 0;
        return;
      end
      for (int i = 0; i < n; i++) begin
        e = hist[i];
        d = (e >= bg_mean) ? e - bg_mean : bg_mean - e;
        sq += d * d;
      end
      bg_var = (sq / (n - 1)) & 64'hFFFF_FFFF_FFFF;
    endfunction

    function int vs_threshold(bit [23:0] energy);
      longint unsigned k2v, d, lhs;
      k2v = longint'(sigma) * sigma * bg_var;
      if (energy < bg_mean) return -1;
      d = longint'(energy - bg_mean) * 16;
      lhs = d * d;
      if (lhs > k2v) return 1;
      if (lhs < k2v) return -1;
      return 0;
    endfunction

    function void note_input(aezv_pkg::in_word_t w);
      bit [15:0] raw;
      bit sgn, zcr_ok, spike;
      int unsigned mag, n, cf;
      bit [23:0] energy;
      longint unsigned c, span;
      aezv_pkg::out_word_t res;
      raw = w.sample;
      sgn = !raw[15];
      mag = raw[15] ? 65536 - raw : raw;
      if (w.op == aezv_pkg::OP_CLEAR) begin
        speech_run = 0;
        silence_run = 0;
        return;
      end
      if (smp_cnt < aezv_pkg::MaxFrame) begin
        if (smp_cnt > 0 && sgn != prev_sign) crossings++;
        prev_sign = sgn;
        abs_sum += mag;
        smp_cnt++;
      end
      if (!w.frame_last) return;
      n = smp_cnt;
      energy = n ? 24'((abs_sum << 8) / n) : 0;
      if (n < 2) zcr_ok = (zlow == 0);
      else begin
        c = longint'(crossings) << 16;
        span = n - 1;
        zcr_ok = c >= longint'(zlow) * span && c <= longint'(zhigh) * span;
      end
      abs_sum = 0; smp_cnt = 0; crossings = 0; prev_sign = 0;
      if (!running) begin
        cf = (cal_frames == 0) ? 1 : cal_frames;
        if (cf > aezv_pkg::HistDepth) cf = aezv_pkg::HistDepth;
        if (cal_cnt < aezv_pkg::HistDepth) hist[cal_cnt] = energy;
        cal_cnt++;
        if (cal_cnt >= cf) begin
          update_stats(cf);
          used = cf;
          running = 1;
          wr_ptr = 0;
        end
        res.speech = 0;
        res.calibrating = 1;
        pending_q.push_back(res);
        return;
      end
      if (vs_threshold(energy) < 0) begin
        hist[wr_ptr % aezv_pkg::HistDepth] = energy;
        wr_ptr = (wr_ptr + 1) % aezv_pkg::HistDepth;
        n = used + 1;
        if (n > aezv_pkg::HistDepth) n = aezv_pkg::HistDepth;
        update_stats(n);
        used = n;
      end
      spike = bg_var != 0 && vs_threshold(energy) > 0;
      if (spike && zcr_ok) begin
        if (speech_run < 255) speech_run++;
        silence_run = 0;
      end else begin
        if (silence_run < 255) silence_run++;
        if (silence_run > aezv_pkg::SilenceMax) speech_run = 0;
      end
      res.speech = speech_run >= min_run;
      res.calibrating = 0;
      pending_q.push_back(res);
    endfunction

    function void check_result(aezv_pkg::out_word_t got);
      aezv_pkg::out_word_t exp_w;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output word %b", got);
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.speech !== exp_w.speech || got.calibrating !== exp_w.calibrating) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: speech exp %b got %b, calibrating exp %b got %b",
                   exp_w.speech, got.speech, exp_w.calibrating, got.calibrating);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [aezv_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [aezv_pkg::CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  aezv_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  aezv_pkg::out_word_t out_data;

  vad_scoreboard sb = new();
  bit idle_en = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int phase_words;
  int cfgs[5][5] = '{'{0, 48, 3277, 32768, 3}, '{255, 0, 0, 65535, 0},
                     '{128, 255, 65535, 0, 255}, '{2, 32, 1000, 60000, 2},
                     '{100, 20, 0, 65535, 1}};

  adaptive_energy_zcr_vad u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // output check and stall bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data);
    if (stall_left == 0) begin
      if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(aezv_pkg::in_word_t w);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk_i); while (in_stall);
    sb.note_input(w);
    phase_words++;
  endtask

  task automatic write_reg(logic [aezv_pkg::CfgIdxW-1:0] idx,
                           logic [aezv_pkg::CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_regs(int cal, int sig, int zl, int zh, int mr);
    write_reg(aezv_pkg::REG_CAL_FRAMES, aezv_pkg::CfgDataW'(cal));
    write_reg(aezv_pkg::REG_SIGMA, aezv_pkg::CfgDataW'(sig));
    write_reg(aezv_pkg::REG_ZCR_LOW, aezv_pkg::CfgDataW'(zl));
    write_reg(aezv_pkg::REG_ZCR_HIGH, aezv_pkg::CfgDataW'(zh));
    write_reg(aezv_pkg::REG_MIN_SPEECH, aezv_pkg::CfgDataW'(mr));
    cfg_we <= 1'b0;
  endtask

  task automatic play_frame(bit loud, int len);
    aezv_pkg::in_word_t w;
    int flip_pct;
    int mag;
    bit neg;
    flip_pct = $urandom_range(0, 100);
    neg = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        w.op = aezv_pkg::OP_CLEAR;
        w.sample = 16'($urandom);
        w.frame_last = $urandom_range(0, 1);
        send_word(w);
      end
      w.op = aezv_pkg::OP_SAMPLE;
      w.frame_last = (i == len - 1);
      if (loud) begin
        if ($urandom_range(0, 99) < flip_pct) neg = !neg;
        mag = $urandom_range(3000, 32767);
        w.sample = neg ? 16'(-mag) : 16'(mag);
        if ($urandom_range(0, 9) == 0) w.sample = 16'($urandom);
      end else begin
        w.sample = 16'($urandom_range(0, 300) - 150);
      end
      send_word(w);
    end
  endtask

  task automatic send_fixed(logic op, int s, logic last);
    aezv_pkg::in_word_t w;
    w.op = op;
    w.sample = 16'(s);
    w.frame_last = last;
    send_word(w);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_regs(4, 16, 0, 65535, 1);

    // directed words: extremes, single sample frames, clears
    send_fixed(aezv_pkg::OP_SAMPLE, 32767, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, -32768, 1'b1);
    send_fixed(aezv_pkg::OP_SAMPLE, 0, 1'b1);
    send_fixed(aezv_pkg::OP_CLEAR, -1, 1'b1);
    send_fixed(aezv_pkg::OP_SAMPLE, -1, 1'b1);
    send_fixed(aezv_pkg::OP_SAMPLE, 5, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, -5, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, 5, 1'b1);
    send_fixed(aezv_pkg::OP_SAMPLE, 40, 1'b1);
    send_fixed(aezv_pkg::OP_SAMPLE, 32767, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, -32768, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, 32767, 1'b1);
    send_fixed(aezv_pkg::OP_SAMPLE, -32768, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, 32767, 1'b1);
    send_fixed(aezv_pkg::OP_SAMPLE, 21845, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, -21846, 1'b1);
    send_fixed(aezv_pkg::OP_CLEAR, 0, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, 10, 1'b1);
    send_fixed(aezv_pkg::OP_SAMPLE, 0, 1'b0);
    send_fixed(aezv_pkg::OP_SAMPLE, 0, 1'b1);

    // overlong frame
    for (int i = 0; i < aezv_pkg::MaxFrame + 6; i++)
      send_fixed(aezv_pkg::OP_SAMPLE, (i % 3 == 0) ? -(i % 200) : (i % 170),
                 i == aezv_pkg::MaxFrame + 5);

    for (int p = 0; p < 5; p++) begin
      drain();
      if (p == 4) idle_en = 1'b0;
      load_regs(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4]);
      phase_words = 0;
      while (phase_words < 12) begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 6)) play_frame(1'b1, $urandom_range(1, 10));
        end else begin
          repeat ($urandom_range(1, 8)) play_frame(1'b0, $urandom_range(1, 10));
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
